/* sv/i2crm_pkg.sv */
// Shared types and codes for the register access bus master.
`default_nettype none
package i2crm_pkg;

	// Request codes carried in the func field
	localparam logic [1:0] FUNC_NONE  = 2'd0;
	localparam logic [1:0] FUNC_PROBE = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// Bus phase codes
	localparam logic [4:0] PH_S0   = 5'd0;
	localparam logic [4:0] PH_S1   = 5'd1;
	localparam logic [4:0] PH_S2   = 5'd2;
	localparam logic [4:0] PH_P0   = 5'd3;
	localparam logic [4:0] PH_P1   = 5'd4;
	localparam logic [4:0] PH_P2   = 5'd5;
	localparam logic [4:0] PH_W0   = 5'd6;
	localparam logic [4:0] PH_W1   = 5'd7;
	localparam logic [4:0] PH_W2   = 5'd8;
	localparam logic [4:0] PH_WA0  = 5'd9;
	localparam logic [4:0] PH_WA1  = 5'd10;
	localparam logic [4:0] PH_R0   = 5'd11;
	localparam logic [4:0] PH_R1   = 5'd12;
	localparam logic [4:0] PH_RA0  = 5'd13;
	localparam logic [4:0] PH_RA1  = 5'd14;
	localparam logic [4:0] PH_RA2  = 5'd15;
	localparam logic [4:0] PH_IDLE = 5'd31;

	// Segment kinds of a transaction
	localparam logic [1:0] SEG_START = 2'd0;
	localparam logic [1:0] SEG_STOP  = 2'd1;
	localparam logic [1:0] SEG_WRITE = 2'd2;
	localparam logic [1:0] SEG_READ  = 2'd3;

	// Register index of the device address
	localparam logic REG_DEVICE_ADDR = 1'b0;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       ack_ok;
		logic [7:0] read_data;
	} res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} seg_t;

endpackage
`default_nettype wire

/* sv/i2c_register_access_master.sv */
// Top level of the register access bus master: request register, sequencer, result register.
//
//   port group   direction  contents
//   tick         in         func, reg_addr, write_data, sda_in per bus tick
//   res          out        scl_out, sda_out, busy_res, done_res, ack_ok, read_data
//   apb          in/out     device_addr at byte address 0
//
// One request per cycle sustained while res is not stalled; each gives one result
// through the request register, then the result register.
// The sequencer state advances only when the request register moves into the result register.
// Reset clears both valid flags and puts the sequencer idle with device_addr zero.
// A stall on res holds the result and the request register, and stalls tick once the
// request register is full.
`default_nettype none
module i2c_register_access_master (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  i2crm_pkg::tick_t  tick,
	output logic              res_valid,
	input  logic              res_stall,
	output i2crm_pkg::res_t   res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import i2crm_pkg::*;

	tick_t      tick_s1;
	logic       valid_s1;
	res_t       res_q;
	logic       res_valid_q;
	res_t       step_res;
	logic [6:0] device_addr;
	logic       blocked;
	logic       adv;

	i2crm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.device_addr (device_addr)
	);

	i2crm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.tick        (tick_s1),
		.device_addr (device_addr),
		.res         (step_res)
	);

	// Flow control between the two registers
	assign blocked    = res_valid_q && res_stall;
	assign adv        = valid_s1 && !blocked;
	assign tick_stall = valid_s1 && blocked;

	// Load the request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_valid && !tick_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) tick_s1 <= tick;
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= step_res;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A finished transaction is always reported as busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> res_q.busy_res)
		else $error("done without busy");

	// Status fields stay zero outside the last tick
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.done_res |-> !res_q.ack_ok && (res_q.read_data == 8'd0))
		else $error("status field set outside done");

	// An idle tick releases both lines
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.busy_res |-> res_q.scl_out && res_q.sda_out)
		else $error("lines driven while idle");

	// A blocked request stays in its register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && blocked |=> valid_s1 && $stable(tick_s1))
		else $error("request register lost a blocked request");

endmodule
`default_nettype wire

/* sv/i2crm_cfg.sv */
// Configuration register file holding the target device address.
`default_nettype none
module i2crm_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [6:0]  device_addr
);
	import i2crm_pkg::*;

	logic [6:0] dev_addr_q;
	logic       hit;

	// Decode the word index
	assign hit    = (paddr[2] == REG_DEVICE_ADDR);
	assign pready = 1'b1;

	// Take the write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'd0;
		end else if (psel && penable && pwrite && hit) begin
			dev_addr_q <= pwdata[6:0];
		end
	end

	// Return the register value on reads
	assign prdata      = hit ? {25'd0, dev_addr_q} : 32'd0;
	assign device_addr = dev_addr_q;

endmodule
`default_nettype wire

/* sv/i2crm_engine.sv */
// Bus phase sequencer: advances the start/byte/ack/stop pattern one tick per request.
`default_nettype none
module i2crm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  i2crm_pkg::tick_t  tick,
	input  logic [6:0]        device_addr,
	output i2crm_pkg::res_t   res
);
	import i2crm_pkg::*;

	logic [4:0] phase_q, phase_d;
	logic [2:0] step_q, step_d;
	logic [2:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] rbyte_q, rbyte_d;
	logic [1:0] kind_q, kind_d;
	logic       acked_q, acked_d;
	logic [7:0] reg_q, reg_d;
	logic [7:0] data_q, data_d;

	// Segment at the given step for a transaction kind
	function automatic seg_t seg_of(input logic [1:0] kind, input logic [2:0] step,
			input logic [7:0] reg_b, input logic [7:0] data_b, input logic [6:0] addr);
		seg_t s;
		s.kind = SEG_STOP;
		s.data = 8'd0;
		if (step == 3'd0) begin
			s.kind = SEG_START;
		end else if (step == 3'd1) begin
			s.kind = SEG_WRITE;
			s.data = {addr, 1'b0};
		end else if (kind == FUNC_WRITE) begin
			if (step == 3'd2) begin
				s.kind = SEG_WRITE;
				s.data = reg_b;
			end else if (step == 3'd3) begin
				s.kind = SEG_WRITE;
				s.data = data_b;
			end
		end else if (kind == FUNC_READ) begin
			if (step == 3'd2) begin
				s.kind = SEG_WRITE;
				s.data = reg_b;
			end else if (step == 3'd3) begin
				s.kind = SEG_START;
			end else if (step == 3'd4) begin
				s.kind = SEG_WRITE;
				s.data = {addr, 1'b1};
			end else if (step == 3'd5) begin
				s.kind = SEG_READ;
			end
		end
		return s;
	endfunction

	// Compute this tick's line levels and the next state
	always_comb begin
		seg_t       nxt;
		logic       b;
		logic       go_next;
		phase_d   = phase_q;
		step_d    = step_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		rbyte_d   = rbyte_q;
		kind_d    = kind_q;
		acked_d   = acked_q;
		reg_d     = reg_q;
		data_d    = data_q;
		go_next   = 1'b0;
		res       = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0, done_res: 1'b0,
			ack_ok: 1'b0, read_data: 8'd0};

		// Accept a new request while idle
		if (phase_q > PH_RA2) begin
			phase_d = PH_IDLE;
			if (tick.func != FUNC_NONE) begin
				kind_d  = tick.func;
				reg_d   = tick.reg_addr;
				data_d  = tick.write_data;
				step_d  = 3'd0;
				acked_d = 1'b0;
				phase_d = PH_S0;
			end
		end

		b = shift_q[bit_cnt_q];

		if (phase_d != PH_IDLE) begin
			res.busy_res = 1'b1;
			unique case (phase_d)
				PH_S0: begin
					phase_d = PH_S1;
				end
				PH_S1: begin
					res.sda_out = 1'b0;
					phase_d     = PH_S2;
				end
				PH_S2: begin
					res.scl_out = 1'b0;
					res.sda_out = 1'b0;
					go_next     = 1'b1;
				end
				PH_P0: begin
					res.scl_out = 1'b0;
					res.sda_out = 1'b0;
					phase_d     = PH_P1;
				end
				PH_P1: begin
					res.sda_out = 1'b0;
					phase_d     = PH_P2;
				end
				PH_P2: begin
					res.done_res = 1'b1;
					if (kind_d == FUNC_PROBE) res.ack_ok = acked_d;
					if (kind_d == FUNC_READ) res.read_data = rbyte_q;
					phase_d = PH_IDLE;
				end
				PH_W0: begin
					res.scl_out = 1'b0;
					res.sda_out = b;
					phase_d     = PH_W1;
				end
				PH_W1: begin
					res.sda_out = b;
					phase_d     = PH_W2;
				end
				PH_W2: begin
					res.scl_out = 1'b0;
					res.sda_out = b;
					if (bit_cnt_q == 3'd0) begin
						phase_d = PH_WA0;
					end else begin
						bit_cnt_d = bit_cnt_q - 3'd1;
						phase_d   = PH_W0;
					end
				end
				PH_WA0: begin
					if (step_d == 3'd1) acked_d = ~tick.sda_in;
					phase_d = PH_WA1;
				end
				PH_WA1: begin
					res.scl_out = 1'b0;
					go_next     = 1'b1;
				end
				PH_R0: begin
					rbyte_d            = rbyte_q;
					rbyte_d[bit_cnt_q] = rbyte_q[bit_cnt_q] | tick.sda_in;
					phase_d            = PH_R1;
				end
				PH_R1: begin
					res.scl_out = 1'b0;
					if (bit_cnt_q == 3'd0) begin
						phase_d = PH_RA0;
					end else begin
						bit_cnt_d = bit_cnt_q - 3'd1;
						phase_d   = PH_R0;
					end
				end
				PH_RA0: begin
					res.scl_out = 1'b0;
					phase_d     = PH_RA1;
				end
				PH_RA1: begin
					phase_d = PH_RA2;
				end
				default: begin
					res.scl_out = 1'b0;
					go_next     = 1'b1;
				end
			endcase
		end

		// Move on to the next segment of the transaction
		nxt = seg_of(kind_d, step_d + 3'd1, reg_d, data_d, device_addr);
		if (go_next) begin
			step_d = step_d + 3'd1;
			unique case (nxt.kind)
				SEG_START: phase_d = PH_S0;
				SEG_WRITE: begin
					shift_d   = nxt.data;
					bit_cnt_d = 3'd7;
					phase_d   = PH_W0;
				end
				SEG_READ: begin
					rbyte_d   = 8'd0;
					bit_cnt_d = 3'd7;
					phase_d   = PH_R0;
				end
				default: phase_d = PH_P0;
			endcase
		end
	end

	// Hold state unless a request advances it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			step_q    <= 3'd0;
			bit_cnt_q <= 3'd7;
			shift_q   <= 8'd0;
			rbyte_q   <= 8'd0;
			kind_q    <= FUNC_NONE;
			acked_q   <= 1'b0;
			reg_q     <= 8'd0;
			data_q    <= 8'd0;
		end else if (adv) begin
			phase_q   <= phase_d;
			step_q    <= step_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			rbyte_q   <= rbyte_d;
			kind_q    <= kind_d;
			acked_q   <= acked_d;
			reg_q     <= reg_d;
			data_q    <= data_d;
		end
	end

endmodule
`default_nettype wire
